@@ rtl/core/wav_pcm_header_parser_core_macros.svh @@
// Assertion macros shared by the WAVE header parser RTL.
`ifndef WAV_PCM_HEADER_PARSER_CORE_MACROS_SVH
`define WAV_PCM_HEADER_PARSER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define WPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpp assertion failed");
// Next-cycle implication, checked out of reset.
`define WPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpp assertion failed");
`else
`define WPP_ASSERT_SAME(lbl, ante, cons)
`define WPP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/wpp_pkg.sv @@
// Package with types, codes and the microcode table of the WAVE header parser.
package wpp_pkg;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_RIFF  = 3'd1;
  localparam logic [2:0] STAT_BAD_WAVE  = 3'd2;
  localparam logic [2:0] STAT_BAD_FMT   = 3'd3;
  localparam logic [2:0] STAT_NOT_PCM   = 3'd4;
  localparam logic [2:0] STAT_BAD_DATA  = 3'd5;
  localparam logic [2:0] STAT_ZERO_FLD  = 3'd6;
  localparam logic [2:0] STAT_TRUNCATED = 3'd7;

  // Chunk tags as little-endian words, and fixed header values.
  localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE       = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT        = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA       = 32'h6174_6164;
  localparam logic [31:0] FMT_WITH_EXTRA = 32'd18;
  localparam logic [31:0] FMT_PCM        = 32'd1;

  // Microprogram addresses, one step per header field.
  localparam logic [3:0] STEP_IDLE  = 4'd0;
  localparam logic [3:0] STEP_RIFF  = 4'd1;
  localparam logic [3:0] STEP_RSIZE = 4'd2;
  localparam logic [3:0] STEP_WAVE  = 4'd3;
  localparam logic [3:0] STEP_FMT   = 4'd4;
  localparam logic [3:0] STEP_FSIZE = 4'd5;
  localparam logic [3:0] STEP_FTAG  = 4'd6;
  localparam logic [3:0] STEP_CHAN  = 4'd7;
  localparam logic [3:0] STEP_RATE  = 4'd8;
  localparam logic [3:0] STEP_BRATE = 4'd9;
  localparam logic [3:0] STEP_ALIGN = 4'd10;
  localparam logic [3:0] STEP_BITS  = 4'd11;
  localparam logic [3:0] STEP_XSIZE = 4'd12;
  localparam logic [3:0] STEP_XSKIP = 4'd13;
  localparam logic [3:0] STEP_DTAG  = 4'd14;
  localparam logic [3:0] STEP_DSIZE = 4'd15;

  // Field lengths as a 2-bit byte count; a four-byte field wraps to zero.
  localparam logic [1:0] LEN_2 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd0;

  typedef enum logic [1:0] {
    CHK_NONE  = 2'd0,
    CHK_TAG   = 2'd1,
    CHK_PCM   = 2'd2,
    CHK_FINAL = 2'd3
  } chk_t;

  typedef enum logic [3:0] {
    DST_NONE  = 4'd0,
    DST_FSIZE = 4'd1,
    DST_CHAN  = 4'd2,
    DST_RATE  = 4'd3,
    DST_BRATE = 4'd4,
    DST_ALIGN = 4'd5,
    DST_BITS  = 4'd6,
    DST_XSIZE = 4'd7
  } dst_t;

  typedef enum logic [1:0] {
    JMP_ALWAYS = 2'd0,
    JMP_FMT18  = 2'd1,
    JMP_XNZ    = 2'd2
  } jmp_t;

  // One control word per step.
  typedef struct packed {
    logic        skip;
    logic [1:0]  len;
    chk_t        chk;
    logic [31:0] tag;
    logic [2:0]  fail;
    dst_t        dst;
    jmp_t        jmp;
    logic [3:0]  next;
    logic [3:0]  alt;
  } uword_t;

  // Request to and answer from the frame-count divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // Microcode table.
  function automatic uword_t wpp_ucode(input logic [3:0] step);
    uword_t w;
    w = '{skip: 1'b0, len: LEN_4, chk: CHK_NONE, tag: 32'd0, fail: STAT_OK,
          dst: DST_NONE, jmp: JMP_ALWAYS, next: STEP_IDLE, alt: STEP_IDLE};
    unique case (step)
      STEP_RIFF: begin
        w.chk = CHK_TAG; w.tag = TAG_RIFF; w.fail = STAT_BAD_RIFF; w.next = STEP_RSIZE;
      end
      STEP_RSIZE: w.next = STEP_WAVE;
      STEP_WAVE: begin
        w.chk = CHK_TAG; w.tag = TAG_WAVE; w.fail = STAT_BAD_WAVE; w.next = STEP_FMT;
      end
      STEP_FMT: begin
        w.chk = CHK_TAG; w.tag = TAG_FMT; w.fail = STAT_BAD_FMT; w.next = STEP_FSIZE;
      end
      STEP_FSIZE: begin
        w.dst = DST_FSIZE; w.next = STEP_FTAG;
      end
      STEP_FTAG: begin
        w.len = LEN_2; w.chk = CHK_PCM; w.fail = STAT_NOT_PCM; w.next = STEP_CHAN;
      end
      STEP_CHAN: begin
        w.len = LEN_2; w.dst = DST_CHAN; w.next = STEP_RATE;
      end
      STEP_RATE: begin
        w.dst = DST_RATE; w.next = STEP_BRATE;
      end
      STEP_BRATE: begin
        w.dst = DST_BRATE; w.next = STEP_ALIGN;
      end
      STEP_ALIGN: begin
        w.len = LEN_2; w.dst = DST_ALIGN; w.next = STEP_BITS;
      end
      STEP_BITS: begin
        w.len = LEN_2; w.dst = DST_BITS; w.jmp = JMP_FMT18;
        w.next = STEP_XSIZE; w.alt = STEP_DTAG;
      end
      STEP_XSIZE: begin
        w.len = LEN_2; w.dst = DST_XSIZE; w.jmp = JMP_XNZ;
        w.next = STEP_XSKIP; w.alt = STEP_DTAG;
      end
      STEP_XSKIP: begin
        w.skip = 1'b1; w.next = STEP_DTAG;
      end
      STEP_DTAG: begin
        w.chk = CHK_TAG; w.tag = TAG_DATA; w.fail = STAT_BAD_DATA; w.next = STEP_DSIZE;
      end
      STEP_DSIZE: w.chk = CHK_FINAL;
      default: w.next = STEP_IDLE;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/wpp_if.sv @@
// Valid/ready channel interfaces for header bytes and parse results.
interface wpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       start_req;
  logic       last;

  modport source (output valid, header_byte, start_req, last, input ready);
  modport sink (input valid, header_byte, start_req, last, output ready);
endinterface

interface wpp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic [34:0] bit_rate;
  logic [15:0] bytes_per_frame;
  logic [15:0] bits_per_sample;
  logic [16:0] data_offset;
  logic [31:0] data_bytes;
  logic [31:0] frame_count;

  modport source (output valid, status, channels, sample_rate, bit_rate, bytes_per_frame,
                  bits_per_sample, data_offset, data_bytes, frame_count, input ready);
  modport sink (input valid, status, channels, sample_rate, bit_rate, bytes_per_frame,
                bits_per_sample, data_offset, data_bytes, frame_count, output ready);
endinterface

@@ rtl/core/wpp_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the frame count.
module wpp_divider
  import wpp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] work_r, work_nxt;
  logic [15:0] dvsr_r, dvsr_nxt;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  // One shift-and-subtract step; the dividend shifts out as quotient bits shift in.
  always_comb begin
    trial    = {rem_r, work_r[31]};
    diff     = trial - {1'b0, dvsr_r};
    ge       = (trial >= {1'b0, dvsr_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = 16'd0;
      work_nxt = req.dividend;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[15:0] : trial[15:0];
      work_nxt = {work_r[30:0], ge};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    dvsr_r <= dvsr_nxt;
  end

  // The final quotient is presented with the last step.
  assign rsp.busy     = busy_r;
  assign rsp.done     = busy_r && (cnt_r == 5'd31);
  assign rsp.quotient = {work_r[30:0], ge};

endmodule

@@ rtl/core/wav_pcm_header_parser_core.sv @@
// Top level of the RIFF/WAVE PCM header parser.
// The parser takes one file byte per cycle on in_ch, unless in_ch stalls, starting
// at offset zero with start_req set, and gives one result word on out_ch per file:
// a status and, when the status is ok, the format fields, the data offset, the bit
// rate and the frame count. After the data size field completes with ok status,
// the frame count comes from a bit-serial divider, so in_ch stalls once per file
// while the divider runs and the result word is offered on the cycle after it ends.
// A failed check or early end gives its result on the cycle after the byte that
// caused it, with all other fields zero. Bytes before a start_req, and after a
// result, are taken and dropped.
// in_ch also stalls while a finished result waits on out_ch.
`include "wav_pcm_header_parser_core_macros.svh"
module wav_pcm_header_parser_core
  import wpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  wpp_in_if.sink           in_ch,
  wpp_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    ST_PARSE = 2'b01,
    ST_DIV   = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  upc_r, upc_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  fb_r, fb_nxt;
  logic [31:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] extra_r, extra_nxt;
  logic [31:0] dsize_r, dsize_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [15:0] o_chan_r, o_chan_nxt;
  logic [31:0] o_rate_r, o_rate_nxt;
  logic [34:0] o_brate_r, o_brate_nxt;
  logic [15:0] o_align_r, o_align_nxt;
  logic [15:0] o_bits_r, o_bits_nxt;
  logic [16:0] o_pos_r, o_pos_nxt;
  logic [31:0] o_dsize_r, o_dsize_nxt;
  logic [31:0] o_frames_r, o_frames_nxt;

  logic        in_ready;
  logic        accept;
  logic        active;
  logic [3:0]  step;
  uword_t      uw;
  logic [16:0] pos_base;
  logic [31:0] shift_base;
  logic [1:0]  fb_base;
  logic [1:0]  fb_inc;
  logic [31:0] asm_word;
  logic        complete;
  logic        have_res;
  logic [2:0]  res_status;
  logic        ok_fire;
  logic [15:0] extra_dec;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // A word is taken while parsing and the output register is free or draining.
  assign in_ready = (state_r == ST_PARSE) && (!ov_r || out_ch.ready);
  assign accept   = in_ch.valid && in_ready;

  // A start byte restarts the program at the RIFF tag with a fresh field.
  assign step       = in_ch.start_req ? STEP_RIFF : upc_r;
  assign pos_base   = in_ch.start_req ? 17'd0 : pos_r;
  assign shift_base = in_ch.start_req ? 32'd0 : shift_r;
  assign fb_base    = in_ch.start_req ? 2'd0 : fb_r;
  assign uw         = wpp_ucode(step);
  assign active     = accept && (step != STEP_IDLE);

  // Little-endian field assembly.
  assign asm_word  = shift_base | ({24'd0, in_ch.header_byte} << {fb_base, 3'b000});
  assign fb_inc    = fb_base + 2'd1;
  assign complete  = !uw.skip && (fb_inc == uw.len);
  assign extra_dec = extra_r - 16'd1;

  // Checks named by the control word, then early end.
  always_comb begin
    have_res   = 1'b0;
    res_status = STAT_OK;
    if (complete) begin
      case (uw.chk)
        CHK_TAG: begin
          have_res   = (asm_word != uw.tag);
          res_status = uw.fail;
        end
        CHK_PCM: begin
          have_res   = (asm_word != FMT_PCM);
          res_status = uw.fail;
        end
        CHK_FINAL: begin
          have_res   = 1'b1;
          res_status = (align_r == 16'd0 || rate_r == 32'd0 || chan_r == 16'd0) ?
                       STAT_ZERO_FLD : STAT_OK;
        end
        default: begin
          have_res   = 1'b0;
          res_status = STAT_OK;
        end
      endcase
    end
    if (!have_res && in_ch.last) begin
      have_res   = 1'b1;
      res_status = STAT_TRUNCATED;
    end
  end

  assign ok_fire = active && have_res && (res_status == STAT_OK);

  // Divider for the frame count.
  assign div_req.start    = ok_fire;
  assign div_req.dividend = asm_word;
  assign div_req.divisor  = align_r;

  wpp_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    fb_nxt    = fb_r;
    fmt_nxt   = fmt_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    brate_nxt = brate_r;
    align_nxt = align_r;
    bits_nxt  = bits_r;
    extra_nxt = extra_r;
    dsize_nxt = dsize_r;
    if (accept && !active) begin
      upc_nxt = STEP_IDLE;
    end
    if (active) begin
      pos_nxt = pos_base + 17'd1;
      upc_nxt = step;
      if (uw.skip) begin
        extra_nxt  = extra_dec;
        shift_nxt  = shift_base;
        fb_nxt     = fb_base;
        if (extra_dec == 16'd0) begin
          upc_nxt = uw.next;
        end
      end else if (complete) begin
        shift_nxt = 32'd0;
        fb_nxt    = 2'd0;
        case (uw.dst)
          DST_FSIZE: fmt_nxt   = asm_word;
          DST_CHAN:  chan_nxt  = asm_word[15:0];
          DST_RATE:  rate_nxt  = asm_word;
          DST_BRATE: brate_nxt = asm_word;
          DST_ALIGN: align_nxt = asm_word[15:0];
          DST_BITS:  bits_nxt  = asm_word[15:0];
          DST_XSIZE: extra_nxt = asm_word[15:0];
          default:   dsize_nxt = asm_word;
        endcase
        case (uw.jmp)
          JMP_FMT18: upc_nxt = (fmt_r == FMT_WITH_EXTRA) ? uw.next : uw.alt;
          JMP_XNZ:   upc_nxt = (asm_word[15:0] != 16'd0) ? uw.next : uw.alt;
          default:   upc_nxt = uw.next;
        endcase
      end else begin
        shift_nxt = asm_word;
        fb_nxt    = fb_inc;
      end
      if (have_res) begin
        upc_nxt = STEP_IDLE;
      end
      if (ok_fire) begin
        dsize_nxt = asm_word;
        state_nxt = ST_DIV;
      end
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      state_nxt = ST_PARSE;
    end
  end

  // Output register: failed results load at once, ok results when the divider ends.
  always_comb begin
    ov_nxt       = ov_r && !out_ch.ready;
    o_status_nxt = o_status_r;
    o_chan_nxt   = o_chan_r;
    o_rate_nxt   = o_rate_r;
    o_brate_nxt  = o_brate_r;
    o_align_nxt  = o_align_r;
    o_bits_nxt   = o_bits_r;
    o_pos_nxt    = o_pos_r;
    o_dsize_nxt  = o_dsize_r;
    o_frames_nxt = o_frames_r;
    if (active && have_res && !ok_fire) begin
      ov_nxt       = 1'b1;
      o_status_nxt = res_status;
      o_chan_nxt   = 16'd0;
      o_rate_nxt   = 32'd0;
      o_brate_nxt  = 35'd0;
      o_align_nxt  = 16'd0;
      o_bits_nxt   = 16'd0;
      o_pos_nxt    = 17'd0;
      o_dsize_nxt  = 32'd0;
      o_frames_nxt = 32'd0;
    end else if (ok_fire) begin
      o_status_nxt = STAT_OK;
      o_chan_nxt   = chan_r;
      o_rate_nxt   = rate_r;
      o_brate_nxt  = {brate_r, 3'b000};
      o_align_nxt  = align_r;
      o_bits_nxt   = bits_r;
      o_pos_nxt    = pos_base + 17'd1;
      o_dsize_nxt  = asm_word;
    end else if (state_r == ST_DIV && div_rsp.done) begin
      ov_nxt       = 1'b1;
      o_frames_nxt = div_rsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PARSE;
      upc_r   <= STEP_IDLE;
      pos_r   <= 17'd0;
      shift_r <= 32'd0;
      fb_r    <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      fb_r    <= fb_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fmt_r      <= fmt_nxt;
    chan_r     <= chan_nxt;
    rate_r     <= rate_nxt;
    brate_r    <= brate_nxt;
    align_r    <= align_nxt;
    bits_r     <= bits_nxt;
    extra_r    <= extra_nxt;
    dsize_r    <= dsize_nxt;
    o_status_r <= o_status_nxt;
    o_chan_r   <= o_chan_nxt;
    o_rate_r   <= o_rate_nxt;
    o_brate_r  <= o_brate_nxt;
    o_align_r  <= o_align_nxt;
    o_bits_r   <= o_bits_nxt;
    o_pos_r    <= o_pos_nxt;
    o_dsize_r  <= o_dsize_nxt;
    o_frames_r <= o_frames_nxt;
  end

  // Port drive.
  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = ov_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.channels        = o_chan_r;
  assign out_ch.sample_rate     = o_rate_r;
  assign out_ch.bit_rate        = o_brate_r;
  assign out_ch.bytes_per_frame = o_align_r;
  assign out_ch.bits_per_sample = o_bits_r;
  assign out_ch.data_offset     = o_pos_r;
  assign out_ch.data_bytes      = o_dsize_r;
  assign out_ch.frame_count     = o_frames_r;

  // The divider runs only while the sequencer waits for it.
  `WPP_ASSERT_SAME(a_div_in_div_state, div_rsp.busy, state_r == ST_DIV)
  // The quotient always finds the output register free.
  `WPP_ASSERT_SAME(a_div_done_reg_free, div_rsp.done, !ov_r)
  // An ok header hands over to the divider on the next cycle.
  `WPP_ASSERT_NEXT(a_ok_starts_div, ok_fire, div_rsp.busy && !in_ch.ready)
  // The skip step is entered only with bytes left to skip.
  `WPP_ASSERT_SAME(a_skip_nonzero, upc_r == STEP_XSKIP, extra_r != 16'd0)

endmodule

@@ sim/wav_pcm_header_parser_core_tb.sv @@
// Self-checking testbench for the RIFF/WAVE PCM header parser core.
`timescale 1ns / 1ps
module wav_pcm_header_parser_core_tb
  import wpp_pkg::*;
();

  localparam int QUIET_LIMIT = 3000;
  localparam int WORD_TARGET = 1000;

  // One input word: a file byte and its framing flags.
  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       lst;
  } wav_byte_t;

  // One parse result, as seen on the result channel.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [34:0] bit_rate;
    logic [15:0] bytes_per_frame;
    logic [15:0] bits_per_sample;
    logic [16:0] data_offset;
    logic [31:0] data_bytes;
    logic [31:0] frame_count;
  } wav_res_t;

  typedef enum int {
    FAULT_NONE = 0,
    FAULT_RIFF = 1,
    FAULT_WAVE = 2,
    FAULT_FMT  = 3,
    FAULT_DATA = 4
  } wav_fault_t;

  // Description of one file: header fields, how it is damaged and framed.
  typedef struct {
    logic [31:0] fsize;
    logic [15:0] ftag;
    logic [15:0] chan;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [15:0] xsize;
    logic [31:0] dsize;
    wav_fault_t  fault;
    int          fault_byte;
    int          cut_at;
    bit          cut_last;
    int          pre;
    int          post;
    bit          drain;
    bit          typed;
    logic [2:0]  typed_status;
  } wav_file_t;

  logic clk = 1'b0;
  logic rst_n;

  wpp_in_if  in_if ();
  wpp_out_if out_if ();

  wav_pcm_header_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #4 clk = ~clk;

  // Shadow parser state.
  logic [3:0]  ph;
  logic [16:0] pos;
  logic [31:0] shf;
  logic [1:0]  nbytes;
  logic [31:0] fsz;
  logic [15:0] chan_q;
  logic [31:0] rate_q;
  logic [31:0] brate_q;
  logic [15:0] align_q;
  logic [15:0] bits_q;
  logic [15:0] xcnt;

  wav_res_t  header_exp_q[$];
  wav_byte_t file_q[$];
  wav_file_t dir_tbl[$];

  bit       calm;
  bit       typed_on;
  wav_res_t typed_res;
  bit       field_bad;
  int       quiet_cycles = 0;
  int       n_fail = 0;
  int       n_checked = 0;
  int       n_sent;
  int       n_used;
  int       n_results;
  int       n_files;

  task automatic clear_parser();
    ph = STEP_IDLE;
    pos = '0;
    shf = '0;
    nbytes = '0;
    fsz = '0;
    chan_q = '0;
    rate_q = '0;
    brate_q = '0;
    align_q = '0;
    bits_q = '0;
    xcnt = '0;
  endtask

  // Byte count of the field taken in each step; four wraps to zero.
  function automatic logic [1:0] field_span(input logic [3:0] step);
    case (step)
      STEP_FTAG, STEP_CHAN, STEP_ALIGN, STEP_BITS, STEP_XSIZE: field_span = LEN_2;
      default: field_span = LEN_4;
    endcase
  endfunction

  // Advance the shadow parser by one word; returns a result when one is due.
  task automatic parse_byte(input wav_byte_t it, output bit used, output bit got,
                            output wav_res_t r);
    logic [31:0] v;
    logic [31:0] dsz;
    int stat;
    used = 1'b0;
    got = 1'b0;
    r = '0;
    stat = -1;
    dsz = '0;
    v = '0;
    if (it.st) begin
      clear_parser();
      ph = STEP_RIFF;
    end
    if (ph != STEP_IDLE) begin
      used = 1'b1;
      pos = pos + 17'd1;
      if (ph == STEP_XSKIP) begin
        xcnt = xcnt - 16'd1;
        if (xcnt == 16'd0) ph = STEP_DTAG;
      end else begin
        shf = shf | ({24'd0, it.b} << (8 * nbytes));
        nbytes = nbytes + 2'd1;
        if (nbytes == field_span(ph)) begin
          v = shf;
          shf = '0;
          nbytes = '0;
          case (ph)
            STEP_RIFF: if (v != TAG_RIFF) stat = STAT_BAD_RIFF; else ph = STEP_RSIZE;
            STEP_RSIZE: ph = STEP_WAVE;
            STEP_WAVE: if (v != TAG_WAVE) stat = STAT_BAD_WAVE; else ph = STEP_FMT;
            STEP_FMT: if (v != TAG_FMT) stat = STAT_BAD_FMT; else ph = STEP_FSIZE;
            STEP_FSIZE: begin
              fsz = v;
              ph = STEP_FTAG;
            end
            STEP_FTAG: if (v != FMT_PCM) stat = STAT_NOT_PCM; else ph = STEP_CHAN;
            STEP_CHAN: begin
              chan_q = v[15:0];
              ph = STEP_RATE;
            end
            STEP_RATE: begin
              rate_q = v;
              ph = STEP_BRATE;
            end
            STEP_BRATE: begin
              brate_q = v;
              ph = STEP_ALIGN;
            end
            STEP_ALIGN: begin
              align_q = v[15:0];
              ph = STEP_BITS;
            end
            STEP_BITS: begin
              bits_q = v[15:0];
              ph = (fsz == FMT_WITH_EXTRA) ? STEP_XSIZE : STEP_DTAG;
            end
            STEP_XSIZE: begin
              xcnt = v[15:0];
              ph = (xcnt != 16'd0) ? STEP_XSKIP : STEP_DTAG;
            end
            STEP_DTAG: if (v != TAG_DATA) stat = STAT_BAD_DATA; else ph = STEP_DSIZE;
            default: begin
              dsz = v;
              if (align_q == 16'd0 || rate_q == 32'd0 || chan_q == 16'd0) begin
                stat = STAT_ZERO_FLD;
              end else begin
                stat = STAT_OK;
              end
            end
          endcase
        end
      end
      // Early end only counts when nothing else was decided on this byte.
      if (stat < 0 && it.lst) stat = STAT_TRUNCATED;
      if (stat >= 0) begin
        got = 1'b1;
        r.status = stat[2:0];
        if (stat == STAT_OK) begin
          r.channels = chan_q;
          r.sample_rate = rate_q;
          r.bit_rate = {brate_q, 3'b000};
          r.bytes_per_frame = align_q;
          r.bits_per_sample = bits_q;
          r.data_offset = pos;
          r.data_bytes = dsz;
          r.frame_count = dsz / {16'd0, align_q};
        end
        ph = STEP_IDLE;
      end
    end
  endtask

  // Drive one word, wait for its handshake, then update the expectations.
  task automatic send_byte(input wav_byte_t it);
    int gap;
    bit used;
    bit got;
    wav_res_t r;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.header_byte <= it.b;
    in_if.start_req <= it.st;
    in_if.last <= it.lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n_sent++;
    parse_byte(it, used, got, r);
    if (used) n_used++;
    if (got) begin
      header_exp_q.push_back(typed_on ? typed_res : r);
      n_results++;
    end
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) file_q.push_back('{b: v[8*k +: 8], st: 1'b0, lst: 1'b0});
  endtask

  function automatic wav_byte_t junk_byte();
    wav_byte_t jb;
    jb.b = 8'($urandom);
    jb.st = 1'b0;
    jb.lst = 1'($urandom_range(0, 1));
    return jb;
  endfunction

  // Lay out the bytes of one file, then damage, cut and pad it.
  task automatic build_file(input wav_file_t f);
    int tag_at;
    int idx;
    file_q.delete();
    put_le(TAG_RIFF, 4);
    put_le($urandom, 4);
    put_le(TAG_WAVE, 4);
    put_le(TAG_FMT, 4);
    put_le(f.fsize, 4);
    put_le({16'd0, f.ftag}, 2);
    put_le({16'd0, f.chan}, 2);
    put_le(f.rate, 4);
    put_le(f.brate, 4);
    put_le({16'd0, f.align}, 2);
    put_le({16'd0, f.bits}, 2);
    if (f.fsize == FMT_WITH_EXTRA) begin
      put_le({16'd0, f.xsize}, 2);
      for (int k = 0; k < f.xsize; k++) put_le($urandom, 1);
    end
    put_le(TAG_DATA, 4);
    put_le(f.dsize, 4);
    file_q[0].st = 1'b1;
    case (f.fault)
      FAULT_RIFF: tag_at = 0;
      FAULT_WAVE: tag_at = 8;
      FAULT_FMT:  tag_at = 12;
      FAULT_DATA: tag_at = file_q.size() - 8;
      default:    tag_at = -1;
    endcase
    if (tag_at >= 0) begin
      idx = tag_at + f.fault_byte;
      file_q[idx].b = file_q[idx].b ^ 8'($urandom_range(1, 255));
    end
    if (f.cut_at >= 0) begin
      while (file_q.size() > f.cut_at + 1) void'(file_q.pop_back());
      file_q[f.cut_at].lst = f.cut_last;
    end else begin
      // Sample bytes after the header are dropped by the block, last included.
      for (int k = 0; k < f.post; k++) file_q.push_back(junk_byte());
      file_q[file_q.size() - 1].lst = 1'b1;
    end
    for (int k = 0; k < f.pre; k++) file_q.push_front(junk_byte());
  endtask

  task automatic run_file(input wav_file_t f);
    if (f.drain && header_exp_q.size() != 0) begin
      in_if.valid <= 1'b0;
      while (header_exp_q.size() != 0) @(posedge clk);
    end
    calm = (f.xsize > 16'd1000) || ($urandom_range(0, 5) == 0);
    typed_on = f.typed;
    typed_res = '0;
    typed_res.status = f.typed_status;
    build_file(f);
    foreach (file_q[k]) send_byte(file_q[k]);
    typed_on = 1'b0;
    n_files++;
  endtask

  function automatic wav_file_t mk(input logic [31:0] fsize, input logic [15:0] ftag,
                                   input logic [15:0] chan, input logic [31:0] rate,
                                   input logic [31:0] brate, input logic [15:0] align,
                                   input logic [15:0] bits, input logic [15:0] xsize,
                                   input logic [31:0] dsize, input wav_fault_t fault,
                                   input int fbyte, input int cut, input bit cut_last,
                                   input int pre, input int post, input bit drain,
                                   input bit typed, input logic [2:0] tstat);
    wav_file_t f;
    f.fsize = fsize;
    f.ftag = ftag;
    f.chan = chan;
    f.rate = rate;
    f.brate = brate;
    f.align = align;
    f.bits = bits;
    f.xsize = xsize;
    f.dsize = dsize;
    f.fault = fault;
    f.fault_byte = fbyte;
    f.cut_at = cut;
    f.cut_last = cut_last;
    f.pre = pre;
    f.post = post;
    f.drain = drain;
    f.typed = typed;
    f.typed_status = tstat;
    return f;
  endfunction

  // Random file: mostly well formed, the rest damaged, cut short or aborted.
  function automatic wav_file_t rand_file();
    wav_file_t f;
    int kind;
    int len;
    case ($urandom_range(0, 4))
      0, 1: f.fsize = 32'd16;
      2, 3: f.fsize = FMT_WITH_EXTRA;
      default: f.fsize = $urandom;
    endcase
    f.xsize = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(9, 64))
                                          : 16'($urandom_range(0, 8));
    f.ftag = 16'(FMT_PCM);
    f.chan = ($urandom_range(0, 9) == 0) ? 16'd0 :
             ($urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom));
    f.rate = ($urandom_range(0, 11) == 0) ? 32'd0 : $urandom;
    f.brate = $urandom;
    f.align = ($urandom_range(0, 9) == 0) ? 16'd0 :
              ($urandom_range(0, 1) ? 16'($urandom_range(1, 16)) : 16'($urandom));
    f.bits = 16'($urandom);
    f.dsize = $urandom;
    f.fault = FAULT_NONE;
    f.fault_byte = $urandom_range(0, 3);
    f.cut_at = -1;
    f.cut_last = 1'b0;
    len = (f.fsize == FMT_WITH_EXTRA) ? 46 + f.xsize : 44;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      f.fault = FAULT_NONE;
    end else if (kind < 72) begin
      f.fault = wav_fault_t'($urandom_range(1, 4));
    end else if (kind < 84) begin
      f.cut_at = $urandom_range(0, len - 1);
      f.cut_last = 1'b1;
    end else if (kind < 92) begin
      f.cut_at = $urandom_range(0, len - 1);
    end else begin
      f.ftag = 16'($urandom);
    end
    f.pre = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    f.post = $urandom_range(0, 3);
    f.drain = ($urandom_range(0, 11) == 0);
    f.typed = 1'b0;
    f.typed_status = STAT_OK;
    return f;
  endfunction

  function automatic void cmp_field(input string nm, input logic [34:0] want_v,
                                    input logic [34:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want_v, got_v);
      field_bad = 1'b1;
    end
  endfunction

  // Result words are checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    wav_res_t seen;
    wav_res_t want;
    if (rst_n && ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.status = out_if.status;
      seen.channels = out_if.channels;
      seen.sample_rate = out_if.sample_rate;
      seen.bit_rate = out_if.bit_rate;
      seen.bytes_per_frame = out_if.bytes_per_frame;
      seen.bits_per_sample = out_if.bits_per_sample;
      seen.data_offset = out_if.data_offset;
      seen.data_bytes = out_if.data_bytes;
      seen.frame_count = out_if.frame_count;
      if (header_exp_q.size() == 0) begin
        $display("%0t: result word with nothing expected, actual status %0d",
                 $time, seen.status);
        n_fail++;
      end else begin
        want = header_exp_q.pop_front();
        field_bad = 1'b0;
        cmp_field("status", want.status, seen.status);
        cmp_field("channels", want.channels, seen.channels);
        cmp_field("sample_rate", want.sample_rate, seen.sample_rate);
        cmp_field("bit_rate", want.bit_rate, seen.bit_rate);
        cmp_field("bytes_per_frame", want.bytes_per_frame, seen.bytes_per_frame);
        cmp_field("bits_per_sample", want.bits_per_sample, seen.bits_per_sample);
        cmp_field("data_offset", want.data_offset, seen.data_offset);
        cmp_field("data_bytes", want.data_bytes, seen.data_bytes);
        cmp_field("frame_count", want.frame_count, seen.frame_count);
        if (field_bad) n_fail++;
        n_checked++;
      end
    end
  end

  // Result side: random stall before each word, none while calm.
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // Ends the run when no word moves on either side for too long.
  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    wav_byte_t nb;
    int n;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.header_byte <= '0;
    in_if.start_req <= 1'b0;
    in_if.last <= 1'b0;
    n_sent = 0;
    n_used = 0;
    n_results = 0;
    n_files = 0;
    calm = 1'b0;
    typed_on = 1'b0;
    typed_res = '0;
    clear_parser();

    // Directed files: fsize ftag chan rate brate align bits xsize dsize,
    // fault fbyte cut cut_last pre post drain typed status.
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, -1, 0, 3, 2, 0, 0, STAT_OK));
    // Zero extra size: the data tag follows the extra size field directly.
    dir_tbl.push_back(mk(18, 1, 1, 8000, 16000, 2, 16, 0, 0,
                         FAULT_NONE, 0, -1, 0, 0, 0, 0, 0, STAT_OK));
    dir_tbl.push_back(mk(18, 1, 6, 48000, 576000, 12, 16, 5, 12345,
                         FAULT_NONE, 0, -1, 0, 0, 1, 0, 0, STAT_OK));
    dir_tbl.push_back(mk(16, 1, 16'hffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff,
                         0, 32'hffffffff, FAULT_NONE, 0, -1, 0, 0, 0, 0, 0, STAT_OK));
    dir_tbl.push_back(mk(16, 1, 1, 1, 1, 1, 0, 0, 32'hffffffff,
                         FAULT_NONE, 0, -1, 0, 0, 0, 0, 0, STAT_OK));
    dir_tbl.push_back(mk(16, 1, 3, 22050, 198450, 3, 8, 0, 10,
                         FAULT_NONE, 0, -1, 0, 0, 3, 0, 0, STAT_OK));
    // Failed checks: every other field of the result reads zero.
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_RIFF, 0, 3, 0, 2, 0, 1, 1, STAT_BAD_RIFF));
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_RIFF, 3, 3, 1, 0, 0, 0, 1, STAT_BAD_RIFF));
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_WAVE, 2, 11, 0, 1, 0, 0, 1, STAT_BAD_WAVE));
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_FMT, 1, 15, 0, 0, 0, 0, 1, STAT_BAD_FMT));
    dir_tbl.push_back(mk(16, 3, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, 21, 0, 0, 0, 0, 1, STAT_NOT_PCM));
    dir_tbl.push_back(mk(16, 16'h0101, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, 21, 0, 0, 0, 0, 1, STAT_NOT_PCM));
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_DATA, 3, -1, 0, 0, 0, 0, 1, STAT_BAD_DATA));
    dir_tbl.push_back(mk(18, 1, 2, 44100, 176400, 4, 16, 2, 1000,
                         FAULT_DATA, 0, -1, 0, 0, 0, 0, 1, STAT_BAD_DATA));
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 0, 16, 0, 1000,
                         FAULT_NONE, 0, -1, 0, 0, 0, 0, 1, STAT_ZERO_FLD));
    dir_tbl.push_back(mk(16, 1, 2, 0, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, -1, 0, 0, 0, 0, 1, STAT_ZERO_FLD));
    dir_tbl.push_back(mk(16, 1, 0, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, -1, 0, 0, 0, 0, 1, STAT_ZERO_FLD));
    // Early end on the first byte, inside the rate field and inside the skip.
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, 0, 1, 0, 0, 0, 1, STAT_TRUNCATED));
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, 25, 1, 0, 0, 0, 1, STAT_TRUNCATED));
    dir_tbl.push_back(mk(18, 1, 2, 44100, 176400, 4, 16, 4, 1000,
                         FAULT_NONE, 0, 39, 1, 0, 0, 0, 1, STAT_TRUNCATED));
    // Last on the byte that completes the header.
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 24, 0, 777,
                         FAULT_NONE, 0, 43, 1, 0, 0, 0, 0, STAT_OK));
    // Abandoned file, restarted by the next start.
    dir_tbl.push_back(mk(16, 1, 2, 44100, 176400, 4, 16, 0, 1000,
                         FAULT_NONE, 0, 17, 0, 0, 0, 0, 0, STAT_OK));
    // Other fmt sizes carry no extra bytes.
    dir_tbl.push_back(mk(20, 1, 2, 32000, 128000, 4, 16, 0, 4096,
                         FAULT_NONE, 0, -1, 0, 0, 0, 0, 0, STAT_OK));
    dir_tbl.push_back(mk(32'hffffffff, 1, 1, 11025, 11025, 1, 8, 0, 99,
                         FAULT_NONE, 0, -1, 0, 0, 0, 0, 0, STAT_OK));
    // A longer extra block moves the data offset well past its usual place.
    dir_tbl.push_back(mk(18, 1, 2, 96000, 768000, 8, 32, 16'd9, 64,
                         FAULT_NONE, 0, -1, 0, 0, 0, 1, 0, STAT_OK));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) run_file(dir_tbl[i]);

    // Random part, with some raw noise words between files.
    while (n_sent < WORD_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          nb = junk_byte();
          nb.st = ($urandom_range(0, 3) == 0);
          send_byte(nb);
        end
      end else begin
        run_file(rand_file());
      end
    end
    in_if.valid <= 1'b0;

    while (header_exp_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("summary: %0d files, %0d words sent, %0d parsed, %0d results checked, %0d failures",
             n_files, n_sent, n_used, n_checked, n_fail);
    $display("summary: tag faults, bad format tags, zero fields, early ends, restarts, extra bytes");
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
